/* rtl/tal_pkg.sv */
// ----------------------------------------------------------------------------
// tal_pkg: shared constants and codes for the thermistor averaging block
// Field widths, table and ring geometry, status and register codes.
// ----------------------------------------------------------------------------
package tal_pkg;

  // geometry
  localparam int SENSORS     = 4;
  localparam int SAMPLES     = 8;
  localparam int TABLE_DEPTH = 512;
  localparam int ADC_BITS    = 12;

  localparam int TBL_AW     = $clog2(TABLE_DEPTH);
  localparam int RING_DEPTH = SENSORS * SAMPLES;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SLOT_W     = $clog2(SAMPLES);
  localparam int SUM_W      = ADC_BITS + SLOT_W;
  localparam int AVG_SHIFT  = 3;

  // interpolation divider: (avg - below) << 8 over (above - below)
  localparam int DIV_NW    = ADC_BITS + 8;
  localparam int DIV_STEPS = DIV_NW / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // port field widths
  localparam int SENSOR_W = 2;
  localparam int INDEX_W  = 9;
  localparam int VALUE_W  = 12;
  localparam int STATUS_W = 2;
  localparam int TEMP_W   = 23;
  localparam int AVG_W    = 12;
  localparam int EC_W     = 10;
  localparam int OFF_W    = 8;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 10;

  // reset values and fixed results
  localparam logic [EC_W-1:0]   EC_RESET  = EC_W'(351);
  localparam logic [OFF_W-1:0]  OFF_RESET = OFF_W'(50);
  localparam logic [TEMP_W-1:0] TEMP_OOR  = TEMP_W'(9999 * 256);

  // item kinds on in_tuser
  localparam logic ACT_TABLE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_ENTRY_COUNT = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_TEMP_OFFSET = CFG_AW'(1);

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ACK   = 2'd2
  } status_t;

endpackage

/* rtl/tal_ram.sv */
// ----------------------------------------------------------------------------
// tal_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tal_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tal_div.sv */
// ----------------------------------------------------------------------------
// tal_div: iterative unsigned divider for the interpolation fraction
// Restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tal_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tal_pkg::DIV_NW-1:0]   num,
  input  logic [tal_pkg::ADC_BITS-1:0] den,
  output logic                         busy,
  output logic [tal_pkg::DIV_NW-1:0]   quot
);

  logic                         busy_r;
  logic [tal_pkg::DIV_CW-1:0]   cnt_r;
  logic [tal_pkg::DIV_NW-1:0]   q_r;
  logic [tal_pkg::DIV_NW-1:0]   q_nxt;
  logic [tal_pkg::ADC_BITS-1:0] rem_r;
  logic [tal_pkg::ADC_BITS-1:0] rem_nxt;
  logic [tal_pkg::ADC_BITS-1:0] den_r;

  // two shift-compare-subtract steps
  always_comb begin
    logic [tal_pkg::ADC_BITS:0] t;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    for (int i = 0; i < 2; i++) begin
      t     = {rem_nxt, q_nxt[tal_pkg::DIV_NW-1]};
      q_nxt = {q_nxt[tal_pkg::DIV_NW-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t        = t - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = t[tal_pkg::ADC_BITS-1:0];
    end
  end

  // control: count down the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= tal_pkg::DIV_CW'(tal_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == tal_pkg::DIV_CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: load operands, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

/* rtl/thermistor_average_and_lookup.sv */
// ----------------------------------------------------------------------------
// thermistor_average_and_lookup: per-sensor ADC averaging and table conversion
// Eight-sample ring per sensor, binary search in a calibration table, linear
// interpolation in Q8, all run by a small microcoded sequencer.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tuser: action; tdata: sensor,index,value
//   out_     out  out_tvalid/out_tready tuser: status; tdata: sensor,temp,avg
//   cfg_     in   cfg_we               cfg_addr: register, cfg_wdata: value
//
// A sample's result comes from eight ring reads through one RAM port, binary
// search steps (at most nine) on the table RAM's single read port, and a
// radix-4 divider for the fraction. A table write is acknowledged without
// these, and an out-of-range sample skips the search and the divider.
// rst_n (synchronous) clears the sequencer, ring slots and ring valid bits
// and resets the registers; the calibration table is not cleared.
// in_tready is high only while the sequencer waits for an item; a result
// held by out_tready keeps the sequencer in its emit step.
// ----------------------------------------------------------------------------
module thermistor_average_and_lookup (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // sensor[1:0] index[10:2] value[22:11]
  input  logic                       in_tuser,   // action[0]
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [39:0]                out_tdata,  // sensor_out[1:0] temperature[24:2]
                                                 // average[36:25]
  output logic [1:0]                 out_tuser,  // status[1:0]
  // configuration
  input  logic                       cfg_we,
  input  logic [tal_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tal_pkg::CFG_DW-1:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // microcode definitions
  // --------------------------------------------------------------------------
  typedef enum logic [3:0] {
    ST_WAIT, ST_DISPATCH, ST_SUM0, ST_SUM_LOOP, ST_SUM_LAST, ST_RNG_HI,
    ST_RNG_LO, ST_RNG_CHK, ST_SRCH_MID, ST_SRCH_CMP, ST_FIN_A, ST_FIN_B,
    ST_FIN_C, ST_DIV_WAIT, ST_FIN_D, ST_EMIT
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_STORE, OP_SUM_RD, OP_SUM_ACC_RD, OP_SUM_ACC, OP_RNG_HI,
    OP_RNG_LO, OP_RNG_CHK, OP_MID, OP_CMP, OP_FIN_A, OP_FIN_B, OP_FIN_C,
    OP_FIN_D, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER, C_NO_ACC, C_TABLE, C_CNT_MORE, C_OOR, C_DONE, C_HIT,
    C_LO_ZERO, C_DIV_BUSY, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } ctrl_t;

  // control store: jump to tgt when cond holds, else go to nxt
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{OP_NONE, C_NEVER, ST_WAIT, ST_WAIT};
    case (s)
      ST_WAIT:     w = '{OP_NONE,       C_NO_ACC,   ST_WAIT,     ST_DISPATCH};
      ST_DISPATCH: w = '{OP_STORE,      C_TABLE,    ST_EMIT,     ST_SUM0};
      ST_SUM0:     w = '{OP_SUM_RD,     C_NEVER,    ST_WAIT,     ST_SUM_LOOP};
      ST_SUM_LOOP: w = '{OP_SUM_ACC_RD, C_CNT_MORE, ST_SUM_LOOP, ST_SUM_LAST};
      ST_SUM_LAST: w = '{OP_SUM_ACC,    C_NEVER,    ST_WAIT,     ST_RNG_HI};
      ST_RNG_HI:   w = '{OP_RNG_HI,     C_NEVER,    ST_WAIT,     ST_RNG_LO};
      ST_RNG_LO:   w = '{OP_RNG_LO,     C_NEVER,    ST_WAIT,     ST_RNG_CHK};
      ST_RNG_CHK:  w = '{OP_RNG_CHK,    C_OOR,      ST_EMIT,     ST_SRCH_MID};
      ST_SRCH_MID: w = '{OP_MID,        C_DONE,     ST_FIN_A,    ST_SRCH_CMP};
      ST_SRCH_CMP: w = '{OP_CMP,        C_HIT,      ST_EMIT,     ST_SRCH_MID};
      ST_FIN_A:    w = '{OP_FIN_A,      C_LO_ZERO,  ST_EMIT,     ST_FIN_B};
      ST_FIN_B:    w = '{OP_FIN_B,      C_NEVER,    ST_WAIT,     ST_FIN_C};
      ST_FIN_C:    w = '{OP_FIN_C,      C_NEVER,    ST_WAIT,     ST_DIV_WAIT};
      ST_DIV_WAIT: w = '{OP_NONE,       C_DIV_BUSY, ST_DIV_WAIT, ST_FIN_D};
      ST_FIN_D:    w = '{OP_FIN_D,      C_NEVER,    ST_WAIT,     ST_EMIT};
      ST_EMIT:     w = '{OP_EMIT,       C_OUT_BUSY, ST_EMIT,     ST_WAIT};
      default:     w = '{OP_NONE,       C_NEVER,    ST_WAIT,     ST_WAIT};
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // declarations
  // --------------------------------------------------------------------------
  step_t                          step_r;
  ctrl_t                          ctrl;
  logic                           jump;

  logic [tal_pkg::EC_W-1:0]       ec_r;
  logic [tal_pkg::OFF_W-1:0]      off_r;

  logic                           act_r;
  logic [tal_pkg::SENSOR_W-1:0]   sensor_r;
  logic [tal_pkg::INDEX_W-1:0]    index_r;
  logic [tal_pkg::VALUE_W-1:0]    value_r;

  logic [tal_pkg::SLOT_W-1:0]     ring_slot_r [tal_pkg::SENSORS];
  logic [tal_pkg::RING_DEPTH-1:0] ring_vld_r;
  logic [tal_pkg::SLOT_W-1:0]     slot;
  logic [tal_pkg::SLOT_W-1:0]     cnt_r;
  logic [tal_pkg::SUM_W-1:0]      sum_r;
  logic                           rvld_r;
  logic [tal_pkg::AVG_W-1:0]      avg;

  logic                           ring_we;
  logic [tal_pkg::RING_AW-1:0]    ring_waddr;
  logic [tal_pkg::RING_AW-1:0]    ring_raddr;
  logic [tal_pkg::ADC_BITS-1:0]   ring_rdata;

  logic                           tbl_we;
  logic [tal_pkg::TBL_AW-1:0]     tbl_raddr;
  logic [tal_pkg::ADC_BITS-1:0]   tbl_rdata;

  logic [tal_pkg::EC_W-1:0]       n_sat;
  logic [tal_pkg::TBL_AW-1:0]     hi_init;
  logic [tal_pkg::TBL_AW-1:0]     lo_r;
  logic [tal_pkg::TBL_AW-1:0]     hi_r;
  logic [tal_pkg::TBL_AW-1:0]     mid_r;
  logic [tal_pkg::TBL_AW-1:0]     mid_c;
  logic [tal_pkg::TBL_AW-1:0]     lo_c;
  logic [tal_pkg::TBL_AW-1:0]     hi_c;
  logic                           done_r;
  logic                           oor_r;
  logic                           oor_now;
  logic                           hit;

  logic [tal_pkg::ADC_BITS-1:0]   below_r;
  logic                           use_div_c;
  logic                           use_div_r;
  logic                           div_start;
  logic                           div_busy;
  logic [tal_pkg::DIV_NW-1:0]     div_quot;
  logic [tal_pkg::DIV_NW-1:0]     frac;
  logic [tal_pkg::TEMP_W-1:0]     off_q8;

  logic [tal_pkg::SENSOR_W-1:0]   res_sensor_r;
  tal_pkg::status_t               res_status_r;
  logic [tal_pkg::TEMP_W-1:0]     res_temp_r;
  logic [tal_pkg::AVG_W-1:0]      res_avg_r;

  logic                           out_valid_r;
  logic                           out_busy;
  logic                           out_load;
  logic [tal_pkg::SENSOR_W-1:0]   out_sensor_r;
  logic [tal_pkg::STATUS_W-1:0]   out_status_r;
  logic [tal_pkg::TEMP_W-1:0]     out_temp_r;
  logic [tal_pkg::AVG_W-1:0]      out_avg_r;

  // --------------------------------------------------------------------------
  // sequencer decode and jump conditions
  // --------------------------------------------------------------------------
  assign ctrl      = ucode(step_r);
  assign in_tready = (step_r == ST_WAIT);
  assign out_busy  = out_valid_r && !out_tready;
  assign out_load  = (ctrl.op == OP_EMIT) && !out_busy;

  assign avg     = sum_r[tal_pkg::SUM_W-1:tal_pkg::AVG_SHIFT];
  assign oor_now = oor_r || (tbl_rdata > avg);
  assign hit     = (avg == tbl_rdata);
  assign off_q8  = tal_pkg::TEMP_W'({off_r, 8'd0});

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_ACC:   jump = !in_tvalid;
      C_TABLE:    jump = (act_r == tal_pkg::ACT_TABLE);
      C_CNT_MORE: jump = (cnt_r != {tal_pkg::SLOT_W{1'b1}});
      C_OOR:      jump = oor_now;
      C_DONE:     jump = done_r;
      C_HIT:      jump = hit;
      C_LO_ZERO:  jump = (lo_r == '0);
      C_DIV_BUSY: jump = div_busy;
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // address and search arithmetic
  // --------------------------------------------------------------------------
  assign slot       = ring_slot_r[sensor_r];
  assign ring_we    = (ctrl.op == OP_STORE) && (act_r == tal_pkg::ACT_SAMPLE);
  assign ring_waddr = tal_pkg::RING_AW'({sensor_r, slot});
  assign ring_raddr = tal_pkg::RING_AW'({sensor_r, cnt_r});

  assign tbl_we = (ctrl.op == OP_STORE) && (act_r == tal_pkg::ACT_TABLE) &&
                  ({1'b0, index_r} < (tal_pkg::INDEX_W + 1)'(tal_pkg::TABLE_DEPTH));

  // clamp the entry count into 1..TABLE_DEPTH
  always_comb begin
    if (ec_r == '0) begin
      n_sat = tal_pkg::EC_W'(1);
    end else if (ec_r > tal_pkg::EC_W'(tal_pkg::TABLE_DEPTH)) begin
      n_sat = tal_pkg::EC_W'(tal_pkg::TABLE_DEPTH);
    end else begin
      n_sat = ec_r;
    end
  end
  assign hi_init = tal_pkg::TBL_AW'(n_sat - 1'b1);

  assign mid_c = tal_pkg::TBL_AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  // narrow the search interval around the compared entry
  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (avg > tbl_rdata) begin
      lo_c = tal_pkg::TBL_AW'(mid_r + 1'b1);
    end else if (avg < tbl_rdata) begin
      hi_c = mid_r;
    end
  end

  // pick the table read address for the current step
  always_comb begin
    case (ctrl.op)
      OP_RNG_HI: tbl_raddr = hi_init;
      OP_RNG_LO: tbl_raddr = '0;
      OP_MID:    tbl_raddr = mid_c;
      OP_FIN_A:  tbl_raddr = tal_pkg::TBL_AW'(lo_r - 1'b1);
      OP_FIN_B:  tbl_raddr = hi_r;
      default:   tbl_raddr = hi_r;
    endcase
  end

  assign use_div_c = (tbl_rdata > below_r) && (avg >= below_r);
  assign div_start = (ctrl.op == OP_FIN_C) && use_div_c;
  assign frac      = use_div_r ? div_quot : '0;

  // --------------------------------------------------------------------------
  // storage and divider
  // --------------------------------------------------------------------------
  tal_ram #(
    .WIDTH (tal_pkg::ADC_BITS),
    .DEPTH (tal_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tal_pkg::TBL_AW'(index_r)),
    .wdata (value_r[tal_pkg::ADC_BITS-1:0]),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  tal_ram #(
    .WIDTH (tal_pkg::ADC_BITS),
    .DEPTH (tal_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (value_r[tal_pkg::ADC_BITS-1:0]),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  tal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({tbl_rdata - below_r, 8'd0} == '0 ? '0 : {avg - below_r, 8'd0}),
    .den   (tbl_rdata - below_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // --------------------------------------------------------------------------
  // control state: step, output valid, ring slots, valid bits, registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_WAIT;
      out_valid_r <= 1'b0;
      ring_vld_r  <= '0;
      ec_r        <= tal_pkg::EC_RESET;
      off_r       <= tal_pkg::OFF_RESET;
      for (int s = 0; s < tal_pkg::SENSORS; s++) begin
        ring_slot_r[s] <= '0;
      end
    end else begin
      step_r <= jump ? ctrl.tgt : ctrl.nxt;

      // hold the result until the transaction completes
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // mark the written ring entry and advance the slot
      if (ring_we) begin
        ring_vld_r[ring_waddr] <= 1'b1;
        ring_slot_r[sensor_r]  <= tal_pkg::SLOT_W'(slot + 1'b1);
      end

      if (cfg_we) begin
        case (cfg_addr)
          tal_pkg::CFG_ENTRY_COUNT: ec_r  <= cfg_wdata;
          tal_pkg::CFG_TEMP_OFFSET: off_r <= cfg_wdata[tal_pkg::OFF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers, driven by the control word
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // capture the accepted item
    if (in_tvalid && in_tready) begin
      act_r    <= in_tuser;
      sensor_r <= in_tdata[1:0];
      index_r  <= in_tdata[10:2];
      value_r  <= in_tdata[22:11];
    end

    rvld_r <= ring_vld_r[ring_raddr];

    case (ctrl.op)
      OP_STORE: begin
        sum_r        <= '0;
        cnt_r        <= '0;
        res_sensor_r <= '0;
        res_status_r <= tal_pkg::STAT_ACK;
        res_temp_r   <= '0;
        res_avg_r    <= '0;
      end
      OP_SUM_RD: begin
        cnt_r <= tal_pkg::SLOT_W'(cnt_r + 1'b1);
      end
      OP_SUM_ACC_RD: begin
        sum_r <= sum_r + tal_pkg::SUM_W'(rvld_r ? ring_rdata : '0);
        cnt_r <= tal_pkg::SLOT_W'(cnt_r + 1'b1);
      end
      OP_SUM_ACC: begin
        sum_r <= sum_r + tal_pkg::SUM_W'(rvld_r ? ring_rdata : '0);
      end
      OP_RNG_HI: begin
        lo_r         <= '0;
        hi_r         <= hi_init;
        done_r       <= 1'b0;
        res_sensor_r <= sensor_r;
        res_avg_r    <= avg;
      end
      OP_RNG_LO: begin
        oor_r <= (avg > tbl_rdata);
      end
      OP_RNG_CHK: begin
        res_status_r <= oor_now ? tal_pkg::STAT_RANGE : tal_pkg::STAT_OK;
        res_temp_r   <= tal_pkg::TEMP_OOR;
      end
      OP_MID: begin
        mid_r <= mid_c;
      end
      OP_CMP: begin
        lo_r       <= lo_c;
        hi_r       <= hi_c;
        done_r     <= (lo_c >= hi_c);
        res_temp_r <= tal_pkg::TEMP_W'({mid_r, 8'd0}) - off_q8;
      end
      OP_FIN_A: begin
        // below the first entry: one degree under the offset
        lo_r       <= tal_pkg::TBL_AW'(lo_r - 1'b1);
        res_temp_r <= tal_pkg::TEMP_W'(0) - tal_pkg::TEMP_W'(256) - off_q8;
      end
      OP_FIN_B: begin
        below_r <= tbl_rdata;
      end
      OP_FIN_C: begin
        use_div_r <= use_div_c;
      end
      OP_FIN_D: begin
        res_temp_r <= tal_pkg::TEMP_W'({lo_r, 8'd0}) + tal_pkg::TEMP_W'(frac) - off_q8;
      end
      default: ;
    endcase

    // load the output register
    if (out_load) begin
      out_sensor_r <= res_sensor_r;
      out_status_r <= res_status_r;
      out_temp_r   <= res_temp_r;
      out_avg_r    <= res_avg_r;
    end
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_avg_r, out_temp_r, out_sensor_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_result_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(step_r) == ST_EMIT)
    else $error("result appeared outside the emit step");

  a_div_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> step_r == ST_DIV_WAIT)
    else $error("divider busy while sequencer is not waiting on it");

  a_accept_dispatch : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> step_r == ST_DISPATCH)
    else $error("accepted transaction not dispatched");

  a_search_order : assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_SRCH_MID && !done_r) |-> lo_r <= hi_r)
    else $error("search bounds crossed");

  a_ack_payload : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == tal_pkg::STAT_ACK) |->
      (out_avg_r == '0 && out_temp_r == '0 && out_sensor_r == '0))
    else $error("table write acknowledge carries data");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of thermistor_average_and_lookup
// A short table of directed transactions on a four-entry table, then ten
// phases at different entry counts and offsets. Each phase loads a
// calibration table and mixes eight-sample bursts per sensor, lone noise
// samples and random table writes. A behavioral predictor tracks the sample
// rings and the table. Every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tal_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 80;
  localparam int DIR_ROWS    = 22;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 140;
  localparam int ADC_MAX     = (1 << ADC_BITS) - 1;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    status_t             status;
    logic [TEMP_W-1:0]   temp;
    logic [AVG_W-1:0]    avg;
  } reading_t;

  typedef struct packed {
    logic                act;
    logic [SENSOR_W-1:0] sen;
    logic [INDEX_W-1:0]  idx;
    logic [VALUE_W-1:0]  val;
    logic                typed;
    status_t             status;
    logic [TEMP_W-1:0]   temp;
    logic [AVG_W-1:0]    avg;
  } stim_row_t;

  // directed transactions on a four-entry table {100, 200, 400, 1000}
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ACT_TABLE,  2'd0, 9'd0,   12'd100,  1'b1, STAT_ACK,   23'd0,             12'd0},
    '{ACT_TABLE,  2'd0, 9'd1,   12'd200,  1'b1, STAT_ACK,   23'd0,             12'd0},
    '{ACT_TABLE,  2'd0, 9'd2,   12'd400,  1'b1, STAT_ACK,   23'd0,             12'd0},
    '{ACT_TABLE,  2'd0, 9'd3,   12'd1000, 1'b1, STAT_ACK,   23'd0,             12'd0},
    '{ACT_TABLE,  2'd3, 9'd511, 12'd4095, 1'b1, STAT_ACK,   23'd0,             12'd0},
    // below the first entry
    '{ACT_SAMPLE, 2'd0, 9'd0,   12'd0,    1'b1, STAT_RANGE, TEMP_OOR,          12'd0},
    // exact hits on entries 0 and 1
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd800,  1'b1, STAT_OK,    TEMP_W'(-12800),   12'd100},
    '{ACT_SAMPLE, 2'd2, 9'd0,   12'd1600, 1'b1, STAT_OK,    TEMP_W'(-12544),   12'd200},
    // interpolation, then above the last entry
    '{ACT_SAMPLE, 2'd3, 9'd0,   12'd2400, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd3, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd3, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd2, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_TABLE,  2'd0, 9'd3,   12'd4095, 1'b1, STAT_ACK,   23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd0, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    // fill sensor 1 with full scale and wrap its ring
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b0, STAT_OK,    23'd0,             12'd0},
    '{ACT_SAMPLE, 2'd1, 9'd0,   12'd4095, 1'b1, STAT_OK,    TEMP_W'(-12032),   12'd4095}
  };

  // per-phase entry count, offset and stall percentage
  localparam int PHASE_EC    [PHASES] = '{1, 0, 16, 2, 512, 1023, 64, 300, 5, 128};
  localparam int PHASE_OFF   [PHASES] = '{0, 255, 128, 17, 255, 0, 200, 93, 7, 50};
  localparam int PHASE_STALL [PHASES] = '{20, 0, 40, 10, 25, 5, 40, 15, 30, 0};

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata   = '0;   // sensor[1:0] index[10:2] value[22:11]
  logic                in_tuser   = 1'b0; // action[0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [39:0]         out_tdata;         // sensor_out[1:0] temperature[24:2] average[36:25]
  logic [1:0]          out_tuser;         // status[1:0]
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = '0;
  logic [CFG_DW-1:0]   cfg_wdata  = '0;

  // predictor state
  logic [VALUE_W-1:0]  cal_words [TABLE_DEPTH];
  bit                  cal_known [TABLE_DEPTH];
  logic [VALUE_W-1:0]  rings     [SENSORS][SAMPLES];
  int                  ring_pos  [SENSORS];
  logic [EC_W-1:0]     ec_reg    = EC_RESET;
  logic [OFF_W-1:0]    off_reg   = OFF_RESET;

  reading_t            pending_readings [$];
  int                  mismatches  = 0;
  int                  cycle_count = 0;
  int                  stall_left  = 0;
  int                  idle_pct    = 0;
  bit                  idle_on     = 1'b0;

  thermistor_average_and_lookup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // clamp the entry count register to the usable table size
  function automatic int entries_in_use();
    if (ec_reg == '0) return 1;
    if (int'(ec_reg) > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(ec_reg);
  endfunction

  // compute the result of one transaction and advance the predictor state
  function automatic reading_t predict_item(input logic act, input logic [SENSOR_W-1:0] sen,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [VALUE_W-1:0] val);
    reading_t r;
    int       sum, avg, n, lo, hi, mid, word, below, above, frac, off, deg;
    bit       done;
    status_t  st;
    r = '0;
    if (act == ACT_TABLE) begin
      cal_words[idx] = val;
      cal_known[idx] = 1'b1;
      r.status = STAT_ACK;
      return r;
    end
    // store the sample and average the ring
    rings[sen][ring_pos[sen]] = val;
    ring_pos[sen] = (ring_pos[sen] + 1) % SAMPLES;
    sum = 0;
    for (int k = 0; k < SAMPLES; k++) sum += int'(rings[sen][k]);
    avg = sum >> AVG_SHIFT;
    // binary search with interpolation between bracketing words
    n   = entries_in_use();
    off = int'(off_reg) * 256;
    lo  = 0;
    hi  = n - 1;
    deg = 0;
    st  = STAT_OK;
    if (int'(cal_words[hi]) < avg || int'(cal_words[0]) > avg) begin
      st  = STAT_RANGE;
      deg = 9999 * 256;
    end else begin
      done = 1'b0;
      while (!done) begin
        mid  = (lo + hi) >> 1;
        word = int'(cal_words[mid]);
        if (avg > word) begin
          lo = mid + 1;
        end else if (avg < word) begin
          hi = mid;
        end else begin
          deg  = mid * 256 - off;
          done = 1'b1;
        end
        if (!done && lo >= hi) begin
          if (lo == 0) begin
            deg = -256 - off;
          end else begin
            lo    = lo - 1;
            below = int'(cal_words[lo]);
            above = int'(cal_words[hi]);
            frac  = 0;
            if (above > below && avg >= below) frac = ((avg - below) << 8) / (above - below);
            deg = lo * 256 + frac - off;
          end
          done = 1'b1;
        end
      end
    end
    r.sensor = sen;
    r.status = st;
    r.temp   = TEMP_W'(deg);
    r.avg    = AVG_W'(avg);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // write one register; the block is idle whenever this is called
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DW'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (addr == CFG_ENTRY_COUNT) ec_reg = EC_W'(value);
    else off_reg = OFF_W'(value);
  endtask

  // present one transaction, wait for acceptance, queue its expected result
  task automatic send_item(input logic act, input logic [SENSOR_W-1:0] sen,
                           input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val,
                           input bit use_typed, input reading_t typed);
    reading_t want;
    int       gap;
    gap = (idle_on && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, val, idx, sen};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_item(act, sen, idx, val);
    pending_readings.push_back(use_typed ? typed : want);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic drain(input int tail);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // stall the result channel in random bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("unexpected result, sensor", int'(out_tdata[1:0]), -1);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[1:0] !== want.sensor)
          flag_mismatch("sensor", int'(out_tdata[1:0]), int'(want.sensor));
        if (out_tuser !== want.status)
          flag_mismatch("status", int'(out_tuser), int'(want.status));
        if (out_tdata[24:2] !== want.temp)
          flag_mismatch("temperature", int'($signed(out_tdata[24:2])), int'($signed(want.temp)));
        if (out_tdata[36:25] !== want.avg)
          flag_mismatch("average", int'(out_tdata[36:25]), int'(want.avg));
      end
    end
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t           row;
    reading_t            typed;
    int                  n, sent, pick, target, lo_w, hi_w, jitter, v, shape, word, step;
    logic [SENSOR_W-1:0] sen;

    for (int s = 0; s < SENSORS; s++) begin
      ring_pos[s] = 0;
      for (int k = 0; k < SAMPLES; k++) rings[s][k] = '0;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) cal_known[i] = 1'b0;

    // hold reset, release on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: four-entry table, offset left at its reset value
    write_reg(CFG_ENTRY_COUNT, 4);
    idle_on  = 1'b1;
    idle_pct = 20;
    for (int r = 0; r < DIR_ROWS; r++) begin
      row          = DIRECTED[r];
      typed.sensor = (row.act == ACT_TABLE) ? '0 : row.sen;
      typed.status = row.status;
      typed.temp   = row.temp;
      typed.avg    = row.avg;
      send_item(row.act, row.sen, row.idx, row.val, row.typed, typed);
    end

    // random phases, each with its own register setting and table
    for (int p = 0; p < PHASES; p++) begin
      drain(4);
      write_reg(CFG_ENTRY_COUNT, PHASE_EC[p]);
      write_reg(CFG_TEMP_OFFSET, PHASE_OFF[p]);
      idle_on  = (p != PHASES - 1);
      idle_pct = PHASE_STALL[p];
      n        = entries_in_use();

      // load the table: mostly rising with flat runs, sometimes scrambled;
      // large tables only fill entries never written
      shape = (n <= 64) ? $urandom_range(0, 3) : 0;
      word  = $urandom_range(0, 200);
      step  = (3900 - word) / n;
      if (step < 1) step = 1;
      for (int i = 0; i < n; i++) begin
        if (shape == 3) word = $urandom_range(0, ADC_MAX);
        else if (i > 0) word = word + $urandom_range(0, step);
        if (word > ADC_MAX) word = ADC_MAX;
        if (n <= 64 || !cal_known[i])
          send_item(ACT_TABLE, SENSOR_W'($urandom_range(0, 3)), INDEX_W'(i),
                    VALUE_W'(word), 1'b0, '0);
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // overwrite any table entry
          send_item(ACT_TABLE, SENSOR_W'($urandom_range(0, 3)),
                    INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                    VALUE_W'($urandom_range(0, ADC_MAX)), 1'b0, '0);
          sent++;
        end else if (pick < 30) begin
          // lone noise sample
          send_item(ACT_SAMPLE, SENSOR_W'($urandom_range(0, SENSORS - 1)),
                    INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                    VALUE_W'($urandom_range(0, ADC_MAX)), 1'b0, '0);
          sent++;
        end else begin
          // burst of one ring's worth aimed at the table span
          lo_w = int'(cal_words[0]);
          hi_w = int'(cal_words[n - 1]);
          if (lo_w > hi_w) begin
            v    = lo_w;
            lo_w = hi_w;
            hi_w = v;
          end
          lo_w = (lo_w > 16) ? lo_w - 16 : 0;
          hi_w = (hi_w + 16 < ADC_MAX) ? hi_w + 16 : ADC_MAX;
          if ($urandom_range(0, 1) == 1) target = int'(cal_words[$urandom_range(0, n - 1)]);
          else target = $urandom_range(lo_w, hi_w);
          jitter = ($urandom_range(0, 1) == 1) ? 0 : 3;
          sen    = SENSOR_W'($urandom_range(0, SENSORS - 1));
          repeat (SAMPLES) begin
            v = target + int'($urandom_range(0, 2 * jitter)) - jitter;
            if (v < 0) v = 0;
            if (v > ADC_MAX) v = ADC_MAX;
            send_item(ACT_SAMPLE, sen, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                      VALUE_W'(v), 1'b0, '0);
          end
          sent += SAMPLES;
        end
      end
    end

    // let the last results drain and watch for strays
    drain(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
